@@ hw/rtl/cabu_pkg.sv @@
// Shared types, widths and constants for the clipped alpha-over blend unit.
`timescale 1ns / 1ps

package cabu_pkg;

    localparam int unsigned REG_W     = 14;
    localparam int unsigned COORD_W   = 15;
    localparam int unsigned ARGB_W    = 32;
    localparam int unsigned INDEX_W   = 26;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned PROD_W    = 2 * CH_W;
    localparam int unsigned NUM_W     = PROD_W + CH_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned COLORS    = 3;
    localparam int unsigned LANES     = COLORS + 1;
    localparam int unsigned ALPHA_LANE = COLORS;
    localparam int unsigned QBITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES = CH_W / QBITS_PER_STAGE;

    // Largest frame dimension; the right and bottom clip edges and the pitch saturate here.
    localparam logic [REG_W-1:0] MAX_DIMENSION = REG_W'(8192);

    localparam logic [CH_W-1:0]   FULL_ALPHA  = 8'd255;
    localparam logic [PROD_W-1:0] ALPHA_ROUND = 16'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_LEFT   = 3'd0,
        REG_CLIP_TOP    = 3'd1,
        REG_CLIP_RIGHT  = 3'd2,
        REG_CLIP_BOTTOM = 3'd3,
        REG_LINE_PITCH  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [REG_W-1:0] clip_left;
        logic [REG_W-1:0] clip_top;
        logic [REG_W-1:0] clip_right;
        logic [REG_W-1:0] clip_bottom;
        logic [REG_W-1:0] line_pitch;
    } clip_cfg_t;

    // After the product stage.
    typedef struct packed {
        logic                           in_clip;
        logic [CH_W-1:0]                sa;
        logic [CH_W-1:0]                inva;
        logic [ARGB_W-1:0]              dst;
        logic [COLORS-1:0][PROD_W-1:0]  ps;
        logic [COLORS-1:0][PROD_W-1:0]  pd;
        logic [PROD_W-1:0]              dw;
        logic [INDEX_W-1:0]             idx_prod;
        logic [COORD_W-1:0]             x;
    } front_t;

    // After the weighted sum stage.
    typedef struct packed {
        logic                           in_clip;
        logic [INDEX_W-1:0]             idx;
        logic [ARGB_W-1:0]              dst;
        logic [PROD_W-1:0]              w;
        logic [COLORS-1:0][NUM_W-1:0]   num;
    } weight_t;

    // Divider pipeline payload; the color lanes divide by w, while the alpha
    // quotient is already final when the request enters the divider.
    typedef struct packed {
        logic                           in_clip;
        logic                           zero;
        logic [INDEX_W-1:0]             idx;
        logic [ARGB_W-1:0]              dst;
        logic [PROD_W-1:0]              w;
        logic [COLORS-1:0][NUM_W-1:0]   rem;
        logic [LANES-1:0][CH_W-1:0]     quot;
    } div_t;

    function automatic logic [REG_W-1:0] sat_dim(input logic [REG_W-1:0] v);
        return (v > MAX_DIMENSION) ? MAX_DIMENSION : v;
    endfunction

endpackage

@@ hw/rtl/cabu_front.sv @@
// First stage: clip test, index product, alpha selection and channel products.
`timescale 1ns / 1ps

module cabu_front
    import cabu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid_in,
    input  clip_cfg_t                 cfg,
    input  logic signed [COORD_W-1:0] pixel_x,
    input  logic signed [COORD_W-1:0] pixel_y,
    input  logic [ARGB_W-1:0]         source_argb,
    input  logic [ARGB_W-1:0]         dest_argb,
    input  logic                      glyph_mode,
    input  logic [CH_W-1:0]           coverage,
    output logic                      valid_out,
    output front_t                    data_out
);

    logic                               valid_reg;
    front_t                             data_reg;
    front_t                             data_next;
    logic signed [COORD_W:0]            x_ext;
    logic signed [COORD_W:0]            y_ext;
    logic signed [COORD_W:0]            left_ext;
    logic signed [COORD_W:0]            top_ext;
    logic signed [COORD_W:0]            right_ext;
    logic signed [COORD_W:0]            bottom_ext;
    logic signed [REG_W:0]              pitch_ext;
    logic signed [COORD_W+REG_W:0]      prod_full;
    logic [CH_W-1:0]                    sa;
    logic [CH_W-1:0]                    da;

    assign x_ext      = {pixel_x[COORD_W-1], pixel_x};
    assign y_ext      = {pixel_y[COORD_W-1], pixel_y};
    assign left_ext   = {{(COORD_W+1-REG_W){1'b0}}, cfg.clip_left};
    assign top_ext    = {{(COORD_W+1-REG_W){1'b0}}, cfg.clip_top};
    assign right_ext  = {{(COORD_W+1-REG_W){1'b0}}, sat_dim(cfg.clip_right)};
    assign bottom_ext = {{(COORD_W+1-REG_W){1'b0}}, sat_dim(cfg.clip_bottom)};
    assign pitch_ext  = {1'b0, sat_dim(cfg.line_pitch)};

    // Signed product; only the low index bits are kept, so the index wraps at 2^26.
    assign prod_full = pixel_y * pitch_ext;

    assign sa = glyph_mode ? coverage : source_argb[ARGB_W-1 -: CH_W];
    assign da = dest_argb[ARGB_W-1 -: CH_W];

    always_comb
    begin
        data_next.in_clip = (x_ext >= left_ext) && (x_ext < right_ext) &&
                            (y_ext >= top_ext) && (y_ext < bottom_ext);
        data_next.sa       = sa;
        data_next.inva     = FULL_ALPHA - sa;
        data_next.dst      = dest_argb;
        data_next.dw       = PROD_W'(da) * PROD_W'(FULL_ALPHA - sa);
        data_next.idx_prod = prod_full[INDEX_W-1:0];
        data_next.x        = pixel_x;
        for (int c = 0; c < COLORS; c++)
        begin
            data_next.ps[c] = PROD_W'(source_argb[c*CH_W +: CH_W]) * PROD_W'(sa);
            data_next.pd[c] = PROD_W'(dest_argb[c*CH_W +: CH_W]) * PROD_W'(da);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ hw/rtl/cabu_weight.sv @@
// Second and third stages: weight, weighted channel sums and divider setup.
`timescale 1ns / 1ps

module cabu_weight
    import cabu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en_sum,
    input  logic   en_prep,
    input  logic   valid_in,
    input  front_t data_in,
    output logic   valid_sum,
    output logic   valid_prep,
    output div_t   data_out
);

    logic    sum_valid_reg;
    logic    prep_valid_reg;
    weight_t sum_reg;
    weight_t sum_next;
    div_t    prep_reg;
    div_t    prep_next;

    // Stage two: w = sa*255 + da*(255-sa), num = sc*sa*255 + dc*da*(255-sa).
    always_comb
    begin
        sum_next.in_clip = data_in.in_clip;
        sum_next.dst     = data_in.dst;
        sum_next.idx     = data_in.idx_prod +
                           {{(INDEX_W-COORD_W){data_in.x[COORD_W-1]}}, data_in.x};
        sum_next.w       = ({data_in.sa, {CH_W{1'b0}}} - PROD_W'(data_in.sa)) + data_in.dw;
        for (int c = 0; c < COLORS; c++)
        begin
            sum_next.num[c] = ({data_in.ps[c], {CH_W{1'b0}}} - NUM_W'(data_in.ps[c])) +
                              NUM_W'(data_in.pd[c]) * NUM_W'(data_in.inva);
        end
    end

    // Stage three: add the rounding terms so every color lane becomes a
    // truncating divide. The alpha is (w+127)/255, done here with the
    // identity n/255 = (n + 1 + n/256) / 256, exact for every n below 2^16.
    always_comb
    begin
        logic [PROD_W-1:0] alpha_num;
        logic [PROD_W-1:0] alpha_div;
        alpha_num = sum_reg.w + ALPHA_ROUND;
        alpha_div = (alpha_num + PROD_W'(1) + (alpha_num >> CH_W)) >> CH_W;
        prep_next.in_clip = sum_reg.in_clip;
        prep_next.zero    = (sum_reg.w == '0);
        prep_next.idx     = sum_reg.idx;
        prep_next.dst     = sum_reg.dst;
        prep_next.w       = sum_reg.w;
        prep_next.quot    = '0;
        for (int c = 0; c < COLORS; c++)
        begin
            prep_next.rem[c] = sum_reg.num[c] + NUM_W'(sum_reg.w >> 1);
        end
        prep_next.quot[ALPHA_LANE] = alpha_div[CH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg  <= 1'b0;
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_sum)
            begin
                sum_valid_reg <= valid_in;
            end
            if (en_prep)
            begin
                prep_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum && valid_in)
        begin
            sum_reg <= sum_next;
        end
        if (en_prep && sum_valid_reg)
        begin
            prep_reg <= prep_next;
        end
    end

    assign valid_sum  = sum_valid_reg;
    assign valid_prep = prep_valid_reg;
    assign data_out   = prep_reg;

endmodule

@@ hw/rtl/cabu_div_step.sv @@
// One divider stage: two restoring quotient bits for each of the three color lanes.
`timescale 1ns / 1ps

module cabu_div_step
    import cabu_pkg::*;
#(
    parameter int unsigned FIRST_QBIT = CH_W - 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic valid_in,
    input  div_t data_in,
    output logic valid_out,
    output div_t data_out
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    always_comb
    begin
        logic [NUM_W-1:0] divisor;
        logic [NUM_W-1:0] trial;
        data_next = data_in;
        divisor   = NUM_W'(data_in.w);
        for (int l = 0; l < COLORS; l++)
        begin
            for (int s = 0; s < QBITS_PER_STAGE; s++)
            begin
                trial = divisor << (FIRST_QBIT - s);
                if (data_next.rem[l] >= trial)
                begin
                    data_next.rem[l] = data_next.rem[l] - trial;
                    data_next.quot[l][FIRST_QBIT - s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ hw/rtl/clipped_alpha_over_blend_unit.sv @@
// A request passes through seven register stages, a valid bit in each, and its result is on
// the output once it reaches the last; an output stall can hold it in any stage on the way.
// Throughput: one pixel request per clock while out_stall is low.
// The depth is set by the four divider stages, each retiring two quotient bits per color lane.
// Reset clears all stage valid bits and sets the clip rectangle to the full frame
// with a pitch of the maximum dimension; the input is not stalled once reset is released.
`timescale 1ns / 1ps

module clipped_alpha_over_blend_unit
    import cabu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_write_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [REG_W-1:0]          cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] pixel_x,
    input  logic signed [COORD_W-1:0] pixel_y,
    input  logic [ARGB_W-1:0]         source_argb,
    input  logic [ARGB_W-1:0]         dest_argb,
    input  logic                      glyph_mode,
    input  logic [CH_W-1:0]           coverage,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      write_enable,
    output logic [INDEX_W-1:0]        pixel_index,
    output logic [ARGB_W-1:0]         blended_argb
);

    // Stage 0 is the product stage, 1 the weight sums, 2 the divider setup,
    // and 3 through 6 the divider stages.
    localparam int unsigned STAGES = 3 + DIV_STAGES;

    clip_cfg_t                  cfg_reg;
    logic [STAGES-1:0]          stage_valid;
    logic [STAGES:0]            stage_en;
    front_t                     front_data;
    div_t                       div_data [DIV_STAGES+1];

    // Configuration registers. Indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_right  <= MAX_DIMENSION;
            cfg_reg.clip_bottom <= MAX_DIMENSION;
            cfg_reg.line_pitch  <= MAX_DIMENSION;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CLIP_LEFT:   cfg_reg.clip_left   <= cfg_data;
                REG_CLIP_TOP:    cfg_reg.clip_top    <= cfg_data;
                REG_CLIP_RIGHT:  cfg_reg.clip_right  <= cfg_data;
                REG_CLIP_BOTTOM: cfg_reg.clip_bottom <= cfg_data;
                REG_LINE_PITCH:  cfg_reg.line_pitch  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads too.
    // Empty stages therefore fill up while the output is stalled, and the
    // input is only stalled when every stage holds a request.
    always_comb
    begin
        stage_en[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            stage_en[k] = !stage_valid[k] || stage_en[k+1];
        end
    end

    assign in_stall = !stage_en[0];

    cabu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (stage_en[0]),
        .valid_in    (in_valid),
        .cfg         (cfg_reg),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .source_argb (source_argb),
        .dest_argb   (dest_argb),
        .glyph_mode  (glyph_mode),
        .coverage    (coverage),
        .valid_out   (stage_valid[0]),
        .data_out    (front_data)
    );

    cabu_weight u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .en_sum     (stage_en[1]),
        .en_prep    (stage_en[2]),
        .valid_in   (stage_valid[0]),
        .data_in    (front_data),
        .valid_sum  (stage_valid[1]),
        .valid_prep (stage_valid[2]),
        .data_out   (div_data[0])
    );

    // Each divider stage handles the next two quotient bits, most significant first.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        cabu_div_step #(
            .FIRST_QBIT (CH_W - 1 - g * QBITS_PER_STAGE)
        ) u_div_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (stage_en[3+g]),
            .valid_in  (stage_valid[2+g]),
            .data_in   (div_data[g]),
            .valid_out (stage_valid[3+g]),
            .data_out  (div_data[g+1])
        );
    end

    // The last divider stage is the output register. A clipped pixel, or one
    // whose combined weight is zero, passes the destination color through.
    assign out_valid    = stage_valid[STAGES-1];
    assign write_enable = div_data[DIV_STAGES].in_clip;
    assign pixel_index  = div_data[DIV_STAGES].in_clip ? div_data[DIV_STAGES].idx : '0;
    assign blended_argb = (div_data[DIV_STAGES].in_clip && !div_data[DIV_STAGES].zero) ?
                          div_data[DIV_STAGES].quot : div_data[DIV_STAGES].dst;

    // The input only stalls when the whole pipeline is full and the output is held.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&stage_valid) && out_stall))
        else $error("input stalled while the pipeline had room");

    // An accepted request always occupies the first stage in the next cycle.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_valid[0])
        else $error("accepted request did not enter the first stage");

    // A delivered result with nothing behind it must not be shown again.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !stage_valid[STAGES-2]) |=> !out_valid)
        else $error("delivered result repeated on the output");

    // A clipped pixel reports a zero index.
    a_clipped_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (pixel_index == '0))
        else $error("clipped pixel carries a nonzero index");

endmodule
